// ===== rtl/core/bgc_pkg.sv =====
// Button gesture classifier package: event, mode and register codes, timing
// constants and the structs shared by the core modules.
// No dependencies.
package bgc_pkg;

	// Parameter defaults
	localparam int TIME_BITS_DEF      = 32;
	localparam int DEBOUNCE_STEPS_DEF = 4;

	// Fixed field widths
	localparam int NOW_W   = 32;
	localparam int HOLD_W  = 16;
	localparam int ROLE_W  = 2;
	localparam int EVENT_W = 3;
	localparam int APB_DW  = 32;
	localparam int APB_AW  = 3;

	// Register decode: one 32-bit register per word, index in paddr[2]
	localparam int        REG_IDX_BIT     = 2;
	localparam logic      REG_HOLD_TIME   = 1'b0;
	localparam logic      REG_BUTTON_ROLE = 1'b1;

	localparam logic [HOLD_W-1:0] HOLD_TIME_RST   = 16'd300;
	localparam logic [ROLE_W-1:0] BUTTON_ROLE_RST = 2'd2;

	// Button roles
	localparam logic [ROLE_W-1:0] ROLE_DOWN  = 2'd1;
	localparam logic [ROLE_W-1:0] ROLE_POWER = 2'd3;

	// Event codes
	localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
	localparam logic [EVENT_W-1:0] EV_PRESS   = 3'd1;
	localparam logic [EVENT_W-1:0] EV_HOLD    = 3'd2;
	localparam logic [EVENT_W-1:0] EV_DOUBLE  = 3'd3;
	localparam logic [EVENT_W-1:0] EV_REPEAT  = 3'd4;
	localparam logic [EVENT_W-1:0] EV_RELEASE = 3'd5;

	// Timing in ms
	localparam logic [HOLD_W-1:0] POWER_HOLD_MS    = 16'd1500;
	localparam logic [HOLD_W-1:0] FAST_REPEAT_MS   = 16'd50;
	localparam logic [HOLD_W-1:0] SLOW_REPEAT_MS   = 16'd200;
	localparam logic [HOLD_W-1:0] DOUBLE_WINDOW_MS = 16'd250;

	// Counter limits
	localparam logic [2:0] FAST_AFTER = 3'd5;
	localparam logic [1:0] CLICK_MAX  = 2'd2;
	localparam logic [2:0] IDLE_MAX   = 3'd6;
	localparam logic [2:0] IDLE_EXIT  = 3'd5;

	typedef enum logic [1:0] {
		MODE_NORMAL,
		MODE_AUTO,
		MODE_POWER
	} mode_t;

	typedef struct packed {
		logic [HOLD_W-1:0] hold_time;
		logic [ROLE_W-1:0] button_role;
	} cfg_t;

	typedef struct packed {
		logic             pin_level;
		logic [NOW_W-1:0] now_ms;
		logic             start_interaction;
		logic             system_sleeping;
		logic             auto_fire_screen;
	} item_t;

	typedef struct packed {
		logic [EVENT_W-1:0] event_code;
		logic               wake_request;
		logic               interaction_done;
	} result_t;

endpackage

// ===== rtl/core/bgc_if.sv =====
// Valid/ready channels of the button gesture classifier: poll samples in,
// classified results out. Depends on bgc_pkg for field widths.
interface bgc_sample_if;
	logic                      valid;
	logic                      ready;
	logic                      pin_level;
	logic [bgc_pkg::NOW_W-1:0] now_ms;
	logic                      start_interaction;
	logic                      system_sleeping;
	logic                      auto_fire_screen;

	modport source (
		output valid, pin_level, now_ms, start_interaction, system_sleeping,
			auto_fire_screen,
		input  ready
	);
	modport sink (
		input  valid, pin_level, now_ms, start_interaction, system_sleeping,
			auto_fire_screen,
		output ready
	);
endinterface

interface bgc_result_if;
	logic                        valid;
	logic                        ready;
	logic [bgc_pkg::EVENT_W-1:0] event_code;
	logic                        wake_request;
	logic                        interaction_done;

	modport source (
		output valid, event_code, wake_request, interaction_done,
		input  ready
	);
	modport sink (
		input  valid, event_code, wake_request, interaction_done,
		output ready
	);
endinterface

// ===== rtl/core/bgc_cfg_regs.sv =====
// APB-style register file: hold_time and button_role.
// Depends on bgc_pkg.
module bgc_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bgc_pkg::APB_AW-1:0]  paddr,
	input  logic [bgc_pkg::APB_DW-1:0]  pwdata,
	output logic [bgc_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output bgc_pkg::cfg_t               cfg
);

	logic                         wr_en;
	logic                         reg_idx;
	logic [bgc_pkg::HOLD_W-1:0]   hold_time_q;
	logic [bgc_pkg::ROLE_W-1:0]   button_role_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[bgc_pkg::REG_IDX_BIT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_time_q   <= bgc_pkg::HOLD_TIME_RST;
			button_role_q <= bgc_pkg::BUTTON_ROLE_RST;
		end else if (wr_en) begin
			case (reg_idx)
				bgc_pkg::REG_HOLD_TIME: begin
					hold_time_q <= pwdata[bgc_pkg::HOLD_W-1:0];
				end
				bgc_pkg::REG_BUTTON_ROLE: begin
					button_role_q <= pwdata[bgc_pkg::ROLE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			bgc_pkg::REG_HOLD_TIME:   prdata = bgc_pkg::APB_DW'(hold_time_q);
			bgc_pkg::REG_BUTTON_ROLE: prdata = bgc_pkg::APB_DW'(button_role_q);
			default:                  prdata = '0;
		endcase
	end

	assign cfg.hold_time   = hold_time_q;
	assign cfg.button_role = button_role_q;

endmodule

// ===== rtl/core/bgc_classify.sv =====
// Gesture state registers and the single-pass next-state/result logic for
// one poll sample. Depends on bgc_pkg.
module bgc_classify #(
	parameter int TIME_BITS      = bgc_pkg::TIME_BITS_DEF,
	parameter int DEBOUNCE_STEPS = bgc_pkg::DEBOUNCE_STEPS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  bgc_pkg::item_t   item,
	input  bgc_pkg::cfg_t    cfg,
	output bgc_pkg::result_t res
);

	localparam int SL_W = $clog2(DEBOUNCE_STEPS + 1);
	localparam logic [SL_W-1:0] SL_MAX = SL_W'(DEBOUNCE_STEPS);

	// State
	logic                 active_q;
	logic [SL_W-1:0]      stable_q;
	logic                 down_q;
	logic [TIME_BITS-1:0] press_stamp_q;
	logic [TIME_BITS-1:0] release_stamp_q;
	logic [TIME_BITS-1:0] repeat_stamp_q;
	logic                 hold_fired_q;
	logic [1:0]           clicks_q;
	logic [2:0]           repeats_q;
	logic [2:0]           idle_q;

	// Next state
	logic                 active_d;
	logic [SL_W-1:0]      stable_d;
	logic                 down_d;
	logic [TIME_BITS-1:0] press_stamp_d;
	logic [TIME_BITS-1:0] release_stamp_d;
	logic [TIME_BITS-1:0] repeat_stamp_d;
	logic                 hold_fired_d;
	logic [1:0]           clicks_d;
	logic [2:0]           repeats_d;
	logic [2:0]           idle_d;

	logic [63:0]          now_ext;
	logic [TIME_BITS-1:0] now_t;
	logic                 raw_down;
	bgc_pkg::mode_t       mode;
	logic                 act0;
	logic [SL_W-1:0]      stable0;
	logic                 down0;
	logic                 hf0;
	logic [1:0]           clicks0;
	logic [2:0]           repeats0;
	logic [2:0]           idle0;
	logic                 deb;
	logic [bgc_pkg::HOLD_W-1:0] limit;
	logic [bgc_pkg::HOLD_W-1:0] gap;
	logic [TIME_BITS-1:0] el_press;
	logic [TIME_BITS-1:0] el_repeat;
	logic [TIME_BITS-1:0] el_release;

	assign now_ext  = 64'(item.now_ms);
	assign now_t    = now_ext[TIME_BITS-1:0];
	assign raw_down = ~item.pin_level;

	always_comb begin
		if (cfg.button_role == bgc_pkg::ROLE_POWER) begin
			mode = bgc_pkg::MODE_POWER;
		end else if (cfg.button_role <= bgc_pkg::ROLE_DOWN && item.auto_fire_screen) begin
			mode = bgc_pkg::MODE_AUTO;
		end else begin
			mode = bgc_pkg::MODE_NORMAL;
		end
	end

	always_comb begin
		// Start of interaction clears the gesture state first
		act0     = item.start_interaction | active_q;
		stable0  = item.start_interaction ? '0 : stable_q;
		down0    = item.start_interaction ? 1'b0 : down_q;
		hf0      = item.start_interaction ? 1'b0 : hold_fired_q;
		clicks0  = item.start_interaction ? 2'd0 : clicks_q;
		repeats0 = item.start_interaction ? 3'd0 : repeats_q;
		idle0    = item.start_interaction ? 3'd0 : idle_q;

		active_d        = act0;
		stable_d        = stable0;
		down_d          = down0;
		press_stamp_d   = press_stamp_q;
		release_stamp_d = release_stamp_q;
		repeat_stamp_d  = repeat_stamp_q;
		hold_fired_d    = hf0;
		clicks_d        = clicks0;
		repeats_d       = repeats0;
		idle_d          = idle0;
		res             = '0;
		deb             = 1'b0;
		limit           = '0;
		gap             = '0;
		el_press        = '0;
		el_repeat       = '0;
		el_release      = '0;

		if (act0) begin
			// Idle counter: count ticks with the button fully up
			if (!raw_down && !down0) begin
				idle_d = (idle0 < bgc_pkg::IDLE_MAX) ? idle0 + 3'd1 : idle0;
			end else begin
				idle_d = 3'd0;
			end

			// Saturating debounce integrator
			if (raw_down) begin
				stable_d = (stable0 < SL_MAX) ? stable0 + SL_W'(1) : stable0;
			end else if (stable0 != '0) begin
				stable_d = stable0 - SL_W'(1);
			end
			deb = (stable_d >= SL_MAX);

			if (deb && !down0 && item.system_sleeping) begin
				// Wake press: record it and end the interaction
				down_d           = 1'b1;
				press_stamp_d    = now_t;
				stable_d         = '0;
				active_d         = 1'b0;
				res.wake_request     = 1'b1;
				res.interaction_done = 1'b1;
			end else begin
				if (deb && !down0) begin
					down_d         = 1'b1;
					press_stamp_d  = now_t;
					repeat_stamp_d = now_t;
					hold_fired_d   = 1'b0;
					clicks_d = (clicks0 < bgc_pkg::CLICK_MAX) ? clicks0 + 2'd1 : clicks0;
				end else if (!deb && down0) begin
					down_d          = 1'b0;
					release_stamp_d = now_t;
					if (mode == bgc_pkg::MODE_NORMAL) begin
						if (!hf0) begin
							res.event_code = bgc_pkg::EV_PRESS;
						end
						clicks_d = 2'd0;
					end else if (hf0) begin
						clicks_d = 2'd0;
					end else if (clicks0 == bgc_pkg::CLICK_MAX) begin
						res.event_code = bgc_pkg::EV_DOUBLE;
						clicks_d       = 2'd0;
					end
				end

				el_press   = now_t - press_stamp_d;
				el_repeat  = now_t - repeat_stamp_d;
				el_release = now_t - release_stamp_d;
				limit = (mode == bgc_pkg::MODE_POWER) ? bgc_pkg::POWER_HOLD_MS : cfg.hold_time;
				gap   = (repeats0 >= bgc_pkg::FAST_AFTER) ? bgc_pkg::FAST_REPEAT_MS :
				        bgc_pkg::SLOW_REPEAT_MS;

				if (down_d) begin
					if (!hold_fired_d && el_press >= TIME_BITS'(limit)) begin
						hold_fired_d = 1'b1;
						if (mode == bgc_pkg::MODE_AUTO) begin
							res.event_code = bgc_pkg::EV_REPEAT;
							repeat_stamp_d = now_t;
							repeats_d      = 3'd1;
							clicks_d       = 2'd0;
						end else begin
							res.event_code = bgc_pkg::EV_HOLD;
						end
					end else if (hold_fired_d && mode == bgc_pkg::MODE_AUTO) begin
						if (el_repeat >= TIME_BITS'(gap)) begin
							res.event_code = bgc_pkg::EV_REPEAT;
							repeat_stamp_d = now_t;
							if (repeats0 < bgc_pkg::FAST_AFTER) begin
								repeats_d = repeats0 + 3'd1;
							end
						end
					end
				end else if (mode != bgc_pkg::MODE_NORMAL && clicks_d == 2'd1 &&
				             el_release >= TIME_BITS'(bgc_pkg::DOUBLE_WINDOW_MS)) begin
					// Double-click window ran out: single press
					res.event_code = bgc_pkg::EV_PRESS;
					clicks_d       = 2'd0;
				end

				// Exit after enough idle ticks
				if (!down_d && idle_d > bgc_pkg::IDLE_EXIT) begin
					if (mode == bgc_pkg::MODE_NORMAL) begin
						res.interaction_done = 1'b1;
					end else if (clicks_d == 2'd0) begin
						if (hold_fired_d && mode == bgc_pkg::MODE_AUTO) begin
							res.event_code = bgc_pkg::EV_RELEASE;
						end
						res.interaction_done = 1'b1;
					end
					if (res.interaction_done) begin
						active_d = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q        <= 1'b0;
			stable_q        <= '0;
			down_q          <= 1'b0;
			press_stamp_q   <= '0;
			release_stamp_q <= '0;
			repeat_stamp_q  <= '0;
			hold_fired_q    <= 1'b0;
			clicks_q        <= 2'd0;
			repeats_q       <= 3'd0;
			idle_q          <= 3'd0;
		end else if (advance) begin
			active_q        <= active_d;
			stable_q        <= stable_d;
			down_q          <= down_d;
			press_stamp_q   <= press_stamp_d;
			release_stamp_q <= release_stamp_d;
			repeat_stamp_q  <= repeat_stamp_d;
			hold_fired_q    <= hold_fired_d;
			clicks_q        <= clicks_d;
			repeats_q       <= repeats_d;
			idle_q          <= idle_d;
		end
	end

`ifndef SYNTHESIS
	a_wake_ends: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.wake_request |->
			res.interaction_done && res.event_code == bgc_pkg::EV_NONE)
		else $error("wake request without end of interaction");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.interaction_done |=> !active_q)
		else $error("interaction still active after done");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !item.start_interaction && !active_q |->
			res == '0 ##1 !active_q)
		else $error("inactive sample changed state or gave a result");

	a_integrator_range: assert property (@(posedge clk) disable iff (!arst_n)
		stable_q <= SL_MAX && clicks_q <= bgc_pkg::CLICK_MAX &&
		repeats_q <= bgc_pkg::FAST_AFTER && idle_q <= bgc_pkg::IDLE_MAX)
		else $error("counter beyond its saturation limit");
`endif

endmodule

// ===== rtl/core/button_gesture_classifier.sv =====
// Button gesture classifier top level: sample input register, gesture core,
// result register and the configuration registers.
// Depends on bgc_pkg, bgc_if, bgc_cfg_regs and bgc_classify.
//
//   channel   kind         payload
//   sample    valid/ready  pin_level, now_ms, start_interaction,
//                          system_sleeping, auto_fire_screen
//   result    valid/ready  event_code, wake_request, interaction_done
//   apb       write/read   hold_time @0x0, button_role @0x4
//
// Every request sits in the sample register, passes the classification logic
// and lands in the result register once that one is free or drains, so the
// result is registered before it is offered downstream. Throughput is one
// request per cycle while results are taken; the gesture state loop closes
// through the core logic and state registers, which sets that rate.
// A stalled result holds in the result register; one more request fills the
// sample register, then sample.ready drops until the result is taken.
// Reset (arst_n low) ends any interaction, clears both registers to
// hold_time 300 and button_role center, and empties both stages.
module button_gesture_classifier #(
	parameter int TIME_BITS      = bgc_pkg::TIME_BITS_DEF,
	parameter int DEBOUNCE_STEPS = bgc_pkg::DEBOUNCE_STEPS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	bgc_sample_if.sink                  sample,
	bgc_result_if.source                result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bgc_pkg::APB_AW-1:0]  paddr,
	input  logic [bgc_pkg::APB_DW-1:0]  pwdata,
	output logic [bgc_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);

	bgc_pkg::cfg_t    cfg;
	bgc_pkg::item_t   item_s1;
	logic             valid_s1;
	bgc_pkg::result_t res_next;
	bgc_pkg::result_t res_s2;
	logic             valid_s2;
	logic             advance;
	logic             take;

	// Advance a full sample register into the result register whenever the
	// result slot is free or being drained this cycle.
	assign advance      = valid_s1 & (~valid_s2 | result.ready);
	assign sample.ready = ~valid_s1 | advance;
	assign take         = sample.valid & sample.ready;

	bgc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sample register: hold the request until the core takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.pin_level         <= sample.pin_level;
			item_s1.now_ms            <= sample.now_ms;
			item_s1.start_interaction <= sample.start_interaction;
			item_s1.system_sleeping   <= sample.system_sleeping;
			item_s1.auto_fire_screen  <= sample.auto_fire_screen;
		end
	end

	bgc_classify #(
		.TIME_BITS      (TIME_BITS),
		.DEBOUNCE_STEPS (DEBOUNCE_STEPS)
	) u_classify (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res_next)
	);

	// Result register: load on advance, drop once taken downstream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign result.valid            = valid_s2;
	assign result.event_code       = res_s2.event_code;
	assign result.wake_request     = res_s2.wake_request;
	assign result.interaction_done = res_s2.interaction_done;

endmodule

// ===== tb/sv/gesture_checker.sv =====
// Result checker for the button gesture classifier: tracks register writes on the APB
// port, predicts one result per accepted sample and compares results in order.
// Depends on bgc_pkg and the bgc_sample_if / bgc_result_if interfaces.
module gesture_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	bgc_sample_if                       smp,
	bgc_result_if                       res,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [bgc_pkg::APB_AW-1:0]  paddr,
	input  logic [bgc_pkg::APB_DW-1:0]  pwdata,
	output int                          fail_count,
	output int                          pending,
	output int                          samples_seen,
	output int                          results_seen,
	output int                          events_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import bgc_pkg::*;

	localparam logic [2:0] DEBOUNCE = 3'(DEBOUNCE_STEPS_DEF);

	// Register copies
	logic [HOLD_W-1:0] hold_ms;
	logic [ROLE_W-1:0] role;

	// Gesture state
	logic              engaged;
	logic [2:0]        integ;
	logic              held_down;
	logic [NOW_W-1:0]  t_press;
	logic [NOW_W-1:0]  t_release;
	logic [NOW_W-1:0]  t_repeat;
	logic              hold_seen;
	logic [1:0]        clicks;
	logic [2:0]        repeats;
	logic [2:0]        idle_ticks;

	result_t pending_results [$];
	result_t want;
	result_t got;
	item_t   smp_item;

	task automatic classify_sample(input item_t s, output result_t r);
		logic       raw_down;
		logic       deb;
		logic [31:0] limit_ms;
		logic [31:0] gap_ms;
		mode_t      mode;
		raw_down = ~s.pin_level;
		r = '0;
		if (s.start_interaction) begin
			engaged    = 1'b1;
			integ      = '0;
			held_down  = 1'b0;
			hold_seen  = 1'b0;
			clicks     = '0;
			repeats    = '0;
			idle_ticks = '0;
		end
		if (!engaged)
			return;

		if (role == ROLE_POWER)
			mode = MODE_POWER;
		else if (role <= ROLE_DOWN && s.auto_fire_screen)
			mode = MODE_AUTO;
		else
			mode = MODE_NORMAL;

		if (!raw_down && !held_down) begin
			if (idle_ticks < IDLE_MAX)
				idle_ticks = idle_ticks + 3'd1;
		end else begin
			idle_ticks = '0;
		end

		if (raw_down) begin
			if (integ < DEBOUNCE)
				integ = integ + 3'd1;
		end else if (integ != 3'd0) begin
			integ = integ - 3'd1;
		end
		deb = (integ >= DEBOUNCE);

		if (deb != held_down) begin
			if (deb) begin
				// press while asleep: wake up and end the interaction
				if (s.system_sleeping) begin
					held_down          = 1'b1;
					t_press            = s.now_ms;
					integ              = '0;
					engaged            = 1'b0;
					r.wake_request     = 1'b1;
					r.interaction_done = 1'b1;
					return;
				end
				held_down = 1'b1;
				t_press   = s.now_ms;
				t_repeat  = s.now_ms;
				hold_seen = 1'b0;
				if (clicks < CLICK_MAX)
					clicks = clicks + 2'd1;
			end else begin
				held_down = 1'b0;
				t_release = s.now_ms;
				if (mode == MODE_NORMAL) begin
					if (!hold_seen)
						r.event_code = EV_PRESS;
					clicks = '0;
				end else if (hold_seen) begin
					clicks = '0;
				end else if (clicks == CLICK_MAX) begin
					r.event_code = EV_DOUBLE;
					clicks = '0;
				end
			end
		end

		if (held_down) begin
			limit_ms = (mode == MODE_POWER) ? 32'(POWER_HOLD_MS) : 32'(hold_ms);
			gap_ms   = (repeats >= FAST_AFTER) ? 32'(FAST_REPEAT_MS) : 32'(SLOW_REPEAT_MS);
			if (!hold_seen && (s.now_ms - t_press) >= limit_ms) begin
				hold_seen = 1'b1;
				if (mode == MODE_AUTO) begin
					r.event_code = EV_REPEAT;
					t_repeat = s.now_ms;
					repeats  = 3'd1;
					clicks   = '0;
				end else begin
					r.event_code = EV_HOLD;
				end
			end else if (hold_seen && mode == MODE_AUTO && (s.now_ms - t_repeat) >= gap_ms) begin
				r.event_code = EV_REPEAT;
				t_repeat = s.now_ms;
				if (repeats < FAST_AFTER)
					repeats = repeats + 3'd1;
			end
		end else if (mode != MODE_NORMAL && clicks == 2'd1 &&
				(s.now_ms - t_release) >= 32'(DOUBLE_WINDOW_MS)) begin
			r.event_code = EV_PRESS;
			clicks = '0;
		end

		if (!held_down && idle_ticks > IDLE_EXIT) begin
			if (mode == MODE_NORMAL) begin
				r.interaction_done = 1'b1;
			end else if (clicks == 2'd0) begin
				if (hold_seen && mode == MODE_AUTO)
					r.event_code = EV_RELEASE;
				r.interaction_done = 1'b1;
			end
			if (r.interaction_done)
				engaged = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ms      = HOLD_TIME_RST;
			role         = BUTTON_ROLE_RST;
			engaged      = 1'b0;
			integ        = '0;
			held_down    = 1'b0;
			t_press      = '0;
			t_release    = '0;
			t_repeat     = '0;
			hold_seen    = 1'b0;
			clicks       = '0;
			repeats      = '0;
			idle_ticks   = '0;
			pending_results.delete();
			fail_count   = 0;
			pending      = 0;
			samples_seen = 0;
			results_seen = 0;
			events_seen  = 0;
		end else begin
			if (res.valid && res.ready) begin
				results_seen++;
				got.event_code       = res.event_code;
				got.wake_request     = res.wake_request;
				got.interaction_done = res.interaction_done;
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result event %0d wake %0b done %0b", $realtime,
						got.event_code, got.wake_request, got.interaction_done);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						$display("%0t: result %0d mismatch: expected event %0d wake %0b done %0b, got event %0d wake %0b done %0b",
							$realtime, results_seen, want.event_code, want.wake_request,
							want.interaction_done, got.event_code, got.wake_request,
							got.interaction_done);
						fail_count++;
					end
				end
			end
			if (smp.valid && smp.ready) begin
				smp_item.pin_level         = smp.pin_level;
				smp_item.now_ms            = smp.now_ms;
				smp_item.start_interaction = smp.start_interaction;
				smp_item.system_sleeping   = smp.system_sleeping;
				smp_item.auto_fire_screen  = smp.auto_fire_screen;
				classify_sample(smp_item, want);
				pending_results.push_back(want);
				samples_seen++;
				if (want.event_code != EV_NONE)
					events_seen++;
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr[REG_IDX_BIT] == REG_BUTTON_ROLE)
					role = pwdata[ROLE_W-1:0];
				else
					hold_ms = pwdata[HOLD_W-1:0];
			end
			pending = pending_results.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the button gesture classifier testbench: clock, reset, APB register writes,
// poll-sample stimulus with idling and back-pressure, and the final verdict.
// Depends on bgc_pkg, the bgc interfaces, gesture_checker and the block itself.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import bgc_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 90;
	localparam int LONG_STALL   = 300;
	localparam int TAIL_CYCLES  = 8;

	// per-phase settings: hold time, role, idle pattern
	// (0 none, 1 sender, 2 receiver, 3 both)
	localparam int PHASE_HOLD [PHASES] = '{0, 300, 65535, 120, 0, 150, 65535, 40};
	localparam int PHASE_ROLE [PHASES] = '{2, 0, 1, 3, 0, 1, 2, 3};

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	int fail_count;
	int pending;
	int samples_seen;
	int results_seen;
	int events_seen;

	int unsigned tx_idle_pct  = 0;
	int unsigned rx_stall_pct = 0;
	int          long_stall_left = 0;
	int          cycles = 0;
	int          items_driven = 0;
	logic [NOW_W-1:0] clock_ms = '0;

	bgc_sample_if smp ();
	bgc_result_if res ();

	button_gesture_classifier dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (smp),
		.result  (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	gesture_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.smp          (smp),
		.res          (res),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.fail_count   (fail_count),
		.pending      (pending),
		.samples_seen (samples_seen),
		.results_seen (results_seen),
		.events_seen  (events_seen)
	);

	always #5 clk = ~clk;

	// Guard the run: end it if the block hangs or the drain never finishes.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles", $realtime, CYCLE_LIMIT);
			$display("** button_gesture_classifier: FAILED **");
			$finish;
		end
	end

	// Result side: drop ready through a long hold-off when one is requested,
	// otherwise stall at random with the current percentage.
	always @(negedge clk) begin
		if (long_stall_left > 0) begin
			res.ready <= 1'b0;
			long_stall_left = long_stall_left - 1;
		end else begin
			res.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Write one register over APB: setup, access, then release the bus.
	// Call at a falling edge; returns at a falling edge.
	task automatic write_reg(input logic idx, input logic [APB_DW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'(idx) << REG_IDX_BIT;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Hold the sender until every predicted result has come back, then let
	// the pipeline settle.
	task automatic wait_drained();
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Offer one sample request; insert random idle cycles first, keep valid high
	// until the block accepts. Returns at the falling edge after acceptance.
	task automatic send_sample(input item_t s);
		while ($urandom_range(99) < tx_idle_pct) begin
			smp.valid <= 1'b0;
			@(negedge clk);
		end
		smp.valid             <= 1'b1;
		smp.pin_level         <= s.pin_level;
		smp.now_ms            <= s.now_ms;
		smp.start_interaction <= s.start_interaction;
		smp.system_sleeping   <= s.system_sleeping;
		smp.auto_fire_screen  <= s.auto_fire_screen;
		do @(posedge clk); while (!smp.ready);
		@(negedge clk);
	endtask

	// Advance the millisecond clock and send one poll tick.
	task automatic tick(input logic pin, input int unsigned dt, input logic start,
			input logic sleep, input logic af, input bit counted);
		item_t s;
		clock_ms = clock_ms + dt;
		s.pin_level         = pin;
		s.now_ms            = clock_ms;
		s.start_interaction = start;
		s.system_sleeping   = sleep;
		s.auto_fire_screen  = af;
		send_sample(s);
		if (counted)
			items_driven++;
	endtask

	// Hold the pin at one level for a run of ticks with jittered spacing,
	// optional contact bounce and a rare restart in the middle.
	task automatic hold_level(input logic pin, input int unsigned len,
			input int unsigned step, input int unsigned bounce_pct, input logic sleep,
			input logic af);
		repeat (len)
			tick(($urandom_range(99) < bounce_pct) ? ~pin : pin,
				step + $urandom_range(0, step / 2), ($urandom_range(0, 99) == 0),
				sleep, af, 1'b1);
	endtask

	// One interaction: a start tick, a gesture, then enough released ticks
	// for the block to close the interaction.
	task automatic play_gesture();
		int unsigned kind;
		int unsigned step;
		int unsigned presses;
		int unsigned bounce_pct;
		int unsigned press_len;
		logic sleep;
		logic af;
		kind = $urandom_range(0, 9);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5, 6: step = $urandom_range(5, 15);
			7, 8: step = $urandom_range(20, 60);
			default: step = $urandom_range(200, 3000);
		endcase
		// jump anywhere on the timeline now and then, wrap included
		if ($urandom_range(0, 7) == 0)
			clock_ms = $urandom();
		sleep      = (kind == 0);
		af         = ($urandom_range(0, 3) != 0);
		bounce_pct = ($urandom_range(0, 2) == 0) ? 12 : 0;
		if (kind == 9) begin
			// noise: random levels, flags and time steps, restarts included
			repeat ($urandom_range(8, 30))
				tick(1'($urandom_range(0, 1)), $urandom_range(0, 300),
					($urandom_range(0, 7) == 0), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'b1);
		end else begin
			presses = (kind >= 6) ? 1 : $urandom_range(1, 3);
			tick(1'b1, step, 1'b1, sleep, af, 1'b1);
			repeat (presses) begin
				press_len = (kind >= 6) ? $urandom_range(20, 160) : $urandom_range(4, 10);
				hold_level(1'b0, press_len, step, bounce_pct, sleep, af);
				hold_level(1'b1, $urandom_range(1, 35), step, bounce_pct, sleep, af);
			end
		end
		hold_level(1'b1, $urandom_range(6, 10), step, 0, sleep, af);
		// a few trailing ticks, not counted toward the phase's items
		repeat ($urandom_range(0, 2))
			tick(1'b1, step, 1'b0, 1'b0, af, 1'b0);
	endtask

	initial begin : stimulus
		int phase_start;
		int unsigned hold;
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		smp.valid             = 1'b0;
		smp.pin_level         = 1'b1;
		smp.now_ms            = '0;
		smp.start_interaction = 1'b0;
		smp.system_sleeping   = 1'b0;
		smp.auto_fire_screen  = 1'b0;
		res.ready             = 1'b0;

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part on the reset settings (center role, 300 ms hold).
		// Pressed pin with no interaction: ignored, nothing reported.
		clock_ms = '0;
		tick(1'b0, 0, 1'b0, 1'b0, 1'b0, 1'b1);
		// Start at the top of the timeline; the press wraps through zero.
		clock_ms = '1;
		tick(1'b1, 0, 1'b1, 1'b0, 1'b0, 1'b1);
		repeat (4) tick(1'b0, 10, 1'b0, 1'b0, 1'b1, 1'b1);
		// Hold after the hold time, then release and let the interaction close.
		tick(1'b0, 300, 1'b0, 1'b0, 1'b0, 1'b1);
		repeat (7) tick(1'b1, 10, 1'b0, 1'b0, 1'b0, 1'b1);
		// Short click: press reported on release.
		tick(1'b1, 10, 1'b1, 1'b0, 1'b0, 1'b1);
		repeat (4) tick(1'b0, 10, 1'b0, 1'b0, 1'b0, 1'b1);
		tick(1'b1, 10, 1'b0, 1'b0, 1'b0, 1'b1);
		// Restart while still active, asleep; the next press wakes the system.
		tick(1'b1, 10, 1'b1, 1'b1, 1'b0, 1'b1);
		repeat (4) tick(1'b0, 10, 1'b0, 1'b1, 1'b0, 1'b1);

		// Random part: one phase per setting and idle pattern.
		for (int p = 0; p < PHASES; p++) begin
			smp.valid <= 1'b0;
			wait_drained();
			hold = (p == PHASES - 1) ? $urandom_range(0, 65535) : PHASE_HOLD[p];
			write_reg(REG_HOLD_TIME, APB_DW'(hold));
			write_reg(REG_BUTTON_ROLE, APB_DW'(PHASE_ROLE[p]));
			case (p % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 74; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 74; end
				default: begin tx_idle_pct = 11; rx_stall_pct = 11; end
			endcase
			phase_start = items_driven;
			while (items_driven - phase_start < PHASE_ITEMS) begin
				play_gesture();
				// Back-pressure: stall results for a long stretch while
				// requests keep coming, so the block fills and stops accepting.
				if (p == 4 && long_stall_left == 0 &&
						items_driven - phase_start > PHASE_ITEMS / 2)
					long_stall_left = LONG_STALL;
				// Pause the sender after gestures that end mid-phase until every result is back.
				if (p == 1 && items_driven - phase_start > PHASE_ITEMS / 2 &&
						items_driven - phase_start < PHASE_ITEMS / 2 + 40) begin
					smp.valid <= 1'b0;
					wait_drained();
				end
			end
		end

		// Drain and settle, then report.
		smp.valid <= 1'b0;
		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("Sent %0d sample requests, checked %0d results with %0d events,",
			samples_seen, results_seen, events_seen);
		$display("across %0d register settings, all roles, hold times 0 to 65535.",
			PHASES + 1);
		if (fail_count == 0 && pending == 0) begin
			$display("** button_gesture_classifier: PASSED **");
		end else begin
			$display("%0d mismatches, %0d results still outstanding", fail_count, pending);
			$display("** button_gesture_classifier: FAILED **");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/bgc_pkg.sv
rtl/core/bgc_if.sv
rtl/core/bgc_cfg_regs.sv
rtl/core/bgc_classify.sv
rtl/core/button_gesture_classifier.sv
tb/sv/gesture_checker.sv
tb/sv/testbench.sv
